@@ hdl/ipv4_longest_prefix_route_table_top_defines.svh @@
// Assertion macros used by the checker file of the route table.
`ifndef IPV4_LONGEST_PREFIX_ROUTE_TABLE_TOP_DEFINES_SVH
`define IPV4_LONGEST_PREFIX_ROUTE_TABLE_TOP_DEFINES_SVH

// Checks that a condition implies another in the same cycle.
`define LPRT_ASSERT_SAME(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("route table check failed in the same cycle");

// Checks that a condition implies another in the following cycle.
`define LPRT_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("route table check failed in the following cycle");

`endif

@@ hdl/lprt_pkg.sv @@
package lprt_pkg;

	// Command codes of an input item.
	localparam logic CMD_ADD    = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	// Result status codes.
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	// Longest meaningful prefix length; larger lengths saturate to it.
	localparam logic [5:0] MAX_LEN = 6'd32;

	// One stored route.
	typedef struct packed {
		logic [31:0] prefix;
		logic [5:0]  length;
		logic [47:0] mac;
		logic [7:0]  port;
	} entry_t;

	// Broadcast from the controller to every cell.
	typedef struct packed {
		logic        ins;
		logic [31:0] addr;
		entry_t      entry;
	} cmd_t;

	// Lookup token handed from cell to cell.
	typedef struct packed {
		logic        active;
		logic        hit;
		logic [47:0] mac;
		logic [7:0]  port;
	} token_t;

	// Prefix mask for a length of 0 to 32; a length of 0 gives an all-zero mask.
	function automatic logic [31:0] len_mask(input logic [5:0] len);
		len_mask = ~(32'hFFFF_FFFF >> len);
	endfunction

endpackage

@@ hdl/lprt_cell.sv @@
module lprt_cell #(
	parameter int IDX   = 0,
	parameter int CNT_W = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lprt_pkg::cmd_t       cmd,
	input  logic [CNT_W-1:0]     count,
	input  lprt_pkg::entry_t     prev_entry,
	input  logic                 prev_take,
	output lprt_pkg::entry_t     entry,
	output logic                 take,
	input  lprt_pkg::token_t     tok_in,
	output lprt_pkg::token_t     tok_out
);
	import lprt_pkg::*;

	entry_t entry_q;
	token_t tok_q;
	logic   occupied;
	logic   hit;

	// The cell holds a route when its place lies below the fill count.
	assign occupied = CNT_W'(IDX) < count;

	// A new route belongs at or before this place when the place is empty or
	// holds a shorter prefix. Along the row this flag only ever turns on once.
	assign take = !occupied || (entry_q.length < cmd.entry.length);

	// Masked compare of the lookup address against the stored prefix.
	assign hit = occupied && ((cmd.addr & len_mask(entry_q.length)) == entry_q.prefix);

	// Insertion: the first taking cell loads the new route, the ones after it
	// take over their left neighbour's route, which shifts the tail by one.
	always_ff @(posedge clk) begin
		if (cmd.ins && take) begin
			entry_q <= prev_take ? prev_entry : cmd.entry;
		end
	end

	// Lookup token stage: the first matching cell claims the token.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (tok_in.active && !tok_in.hit && hit) begin
			tok_q <= '{active: 1'b1, hit: 1'b1, mac: entry_q.mac, port: entry_q.port};
		end else begin
			tok_q <= tok_in;
		end
	end

	assign entry   = entry_q;
	assign tok_out = tok_q;

endmodule

@@ hdl/lprt_ctrl.sv @@
module lprt_ctrl #(
	parameter int DEPTH = 64,
	parameter int CNT_W = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 command,
	input  logic [31:0]          ip_address,
	input  logic [5:0]           prefix_length,
	input  logic [47:0]          hop_mac,
	input  logic [7:0]           hop_port,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           status,
	output logic [47:0]          found_mac,
	output logic [7:0]           found_port,
	output lprt_pkg::cmd_t       cmd,
	output logic [CNT_W-1:0]     count,
	output lprt_pkg::token_t     tok_start,
	input  lprt_pkg::token_t     tok_end
);
	import lprt_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_LOOK = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t           state_q;
	logic             cmd_q;
	logic [31:0]      addr_q;
	logic [5:0]       len_q;
	logic [47:0]      mac_q;
	logic [7:0]       port_q;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0]       res_status_q;
	logic [47:0]      res_mac_q;
	logic [7:0]       res_port_q;
	logic             out_valid_q;
	logic [1:0]       status_q;
	logic [47:0]      found_mac_q;
	logic [7:0]       found_port_q;
	logic             full;
	logic             in_fire;
	logic             out_load;

	assign full     = cnt_q == CNT_W'(DEPTH);
	assign in_ready = state_q == S_IDLE;
	assign in_fire  = in_valid && in_ready;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// Broadcast to the cells: insertion strobe, lookup address and new route.
	assign cmd.ins   = (state_q == S_EXEC) && (cmd_q == CMD_ADD) && !full;
	assign cmd.addr  = addr_q;
	assign cmd.entry = '{prefix: addr_q, length: len_q, mac: mac_q, port: port_q};
	assign count     = cnt_q;

	// A lookup enters the chain as a fresh token at the first cell.
	assign tok_start = '{active: (state_q == S_EXEC) && (cmd_q == CMD_LOOKUP),
		hit: 1'b0, mac: '0, port: '0};

	// Capture of the accepted item; over-long prefix lengths saturate.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q  <= command;
			addr_q <= ip_address;
			len_q  <= (prefix_length > MAX_LEN) ? MAX_LEN : prefix_length;
			mac_q  <= hop_mac;
			port_q <= hop_port;
		end
	end

	// Sequencer and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (cmd_q == CMD_ADD) begin
						if (!full) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
						state_q <= S_DONE;
					end else begin
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					if (tok_end.active) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Pending result of the current item.
	always_ff @(posedge clk) begin
		if (state_q == S_EXEC && cmd_q == CMD_ADD) begin
			res_status_q <= full ? ST_FULL : ST_OK;
			res_mac_q    <= '0;
			res_port_q   <= '0;
		end else if (state_q == S_LOOK && tok_end.active) begin
			res_status_q <= tok_end.hit ? ST_OK : ST_MISS;
			res_mac_q    <= tok_end.hit ? tok_end.mac : 48'd0;
			res_port_q   <= tok_end.hit ? tok_end.port : 8'd0;
		end
	end

	// Output register, which lets the next item in while a result waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q     <= res_status_q;
			found_mac_q  <= res_mac_q;
			found_port_q <= res_port_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign found_mac  = found_mac_q;
	assign found_port = found_port_q;

endmodule

@@ hdl/ipv4_longest_prefix_route_table_top.sv @@
// IPv4 route table with longest-prefix lookup, built as a row of TABLE_DEPTH
// cells that each hold one route, kept in order of falling prefix length. An
// add places the route ahead of the first stored route with a shorter prefix,
// every cell either keeping its route, loading the new one or taking its left
// neighbour's. A lookup travels as a token down the row, one cell per cycle,
// and the first cell whose masked compare matches fills in the next hop; that
// walk sets the rate. One item is worked on at a time, and the next input
// transfer is taken as soon as the result has moved to the output register.
// An add to a full table changes nothing and reports table full.
module ipv4_longest_prefix_route_table_top #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [31:0] ip_address,
	input  logic [5:0]  prefix_length,
	input  logic [47:0] hop_mac,
	input  logic [7:0]  hop_port,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [47:0] found_mac,
	output logic [7:0]  found_port
);
	import lprt_pkg::*;

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	cmd_t             cmd;
	logic [CNT_W-1:0] count;
	token_t           tok [TABLE_DEPTH+1];
	entry_t           ent [TABLE_DEPTH];
	logic             take [TABLE_DEPTH];
	entry_t           prev_ent [TABLE_DEPTH];
	logic             prev_take [TABLE_DEPTH];

	lprt_ctrl #(
		.DEPTH (TABLE_DEPTH),
		.CNT_W (CNT_W)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.ip_address    (ip_address),
		.prefix_length (prefix_length),
		.hop_mac       (hop_mac),
		.hop_port      (hop_port),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.found_mac     (found_mac),
		.found_port    (found_port),
		.cmd           (cmd),
		.count         (count),
		.tok_start     (tok[0]),
		.tok_end       (tok[TABLE_DEPTH])
	);

	// The row of route cells, each linked to its left neighbour.
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign prev_ent[i]  = '0;
			assign prev_take[i] = 1'b0;
		end else begin : g_link
			assign prev_ent[i]  = ent[i-1];
			assign prev_take[i] = take[i-1];
		end

		lprt_cell #(
			.IDX   (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.count      (count),
			.prev_entry (prev_ent[i]),
			.prev_take  (prev_take[i]),
			.entry      (ent[i]),
			.take       (take[i]),
			.tok_in     (tok[i]),
			.tok_out    (tok[i+1])
		);
	end

endmodule

@@ hdl/lprt_checker.sv @@
`include "ipv4_longest_prefix_route_table_top_defines.svh"

module lprt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [47:0] found_mac,
	input logic [7:0]  found_port
);
	import lprt_pkg::*;

	// A waiting result holds until its transfer.
	`LPRT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(found_mac) && $stable(found_port))

	// Only the three defined status codes appear.
	`LPRT_ASSERT_SAME(a_status_code, clk, arst_n, out_valid, status == ST_OK || status == ST_MISS || status == ST_FULL)

	// A miss or a refused add carries no next hop.
	`LPRT_ASSERT_SAME(a_zero_hop, clk, arst_n, out_valid && status != ST_OK, found_mac == 48'd0 && found_port == 8'd0)

	// Items are worked on one at a time: the input closes after a transfer in.
	`LPRT_ASSERT_NEXT(a_one_item, clk, arst_n, in_valid && in_ready, !in_ready)

endmodule

bind ipv4_longest_prefix_route_table_top lprt_checker u_lprt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.status     (status),
	.found_mac  (found_mac),
	.found_port (found_port)
);
